// ===== sv/cfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared widths, signal descriptor ROM, identifier groups and pipeline types
// for the CAN signal frame decoder.
// ----------------------------------------------------------------------------
package cfd_pkg;

   localparam int NUM_SIGNALS    = 26;
   localparam int MAX_FIELD_BITS = 32;
   localparam int FIELD_LIMIT    = (MAX_FIELD_BITS < 32) ? MAX_FIELD_BITS : 32;

   localparam int ID_W     = 11;
   localparam int DATA_W   = 64;
   localparam int IDX_W    = 5;
   localparam int RAW_W    = 32;
   localparam int SCALED_W = 64;
   localparam int FACTOR_W = 48;
   localparam int HALF_W   = 24;
   localparam int PROD_W   = 56;
   localparam int OFF_W    = 16;
   localparam int CNT_W    = 3;

   // identifiers 0x500..0x507 share these upper eight bits
   localparam logic [7:0] ID_GROUP_BASE = 8'hA0;

   // factors, unsigned Q1.47
   localparam logic [FACTOR_W-1:0] F_ACC   = 48'd17179869184;
   localparam logic [FACTOR_W-1:0] F_GYR   = 48'd1073728519909;
   localparam logic [FACTOR_W-1:0] F_ANG   = 48'd1546142047072;
   localparam logic [FACTOR_W-1:0] F_MILLI = 48'd140737488355;
   localparam logic [FACTOR_W-1:0] F_ONE   = 48'd140737488355328;
   localparam logic [FACTOR_W-1:0] F_DEG7  = 48'd14073749;
   localparam logic [FACTOR_W-1:0] F_SPD   = 48'd429488593214;
   localparam logic [FACTOR_W-1:0] F_CENTI = 48'd1407374883553;

   // rounding and saturation of the Q32.32 result
   localparam logic [PROD_W-1:0]   ROUND_HALF = 56'h00_0000_0000_4000;
   localparam logic [PROD_W-1:0]   OVF_LIMIT  = 56'h40_0100_0000_0000;
   localparam logic [SCALED_W-1:0] SCALED_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [5:0]              start;
      logic [5:0]              len;
      logic [FACTOR_W-1:0]     factor;
      logic signed [OFF_W-1:0] offset;
   } desc_type;

   typedef struct packed {
      logic [IDX_W-1:0] first;
      logic [CNT_W-1:0] count;
   } group_type;

   // one signal job handed from the sequencer to the pipeline
   typedef struct packed {
      logic [IDX_W-1:0] index;
      logic             unknown;
      logic             last;
   } task_type;

   // per-result fields that ride along the arithmetic stages
   typedef struct packed {
      logic [IDX_W-1:0]        index;
      logic [RAW_W-1:0]        raw;
      logic signed [OFF_W-1:0] offset;
      logic                    unknown;
      logic                    last;
   } meta_type;

   function automatic desc_type mk_desc(input logic [5:0] start, input logic [5:0] len,
                                        input logic [FACTOR_W-1:0] factor,
                                        input logic signed [OFF_W-1:0] offset);
      desc_type d;
      d.start  = start;
      d.len    = len;
      d.factor = factor;
      d.offset = offset;
      return d;
   endfunction

   function automatic desc_type cfd_rom(input logic [IDX_W-1:0] idx);
      desc_type d;
      case (idx)
         5'd0:    d = mk_desc(6'd7,  6'd16, F_ACC,   -16'sd4);
         5'd1:    d = mk_desc(6'd23, 6'd16, F_ACC,   -16'sd4);
         5'd2:    d = mk_desc(6'd39, 6'd16, F_ACC,   -16'sd4);
         5'd3:    d = mk_desc(6'd7,  6'd16, F_GYR,   -16'sd250);
         5'd4:    d = mk_desc(6'd23, 6'd16, F_GYR,   -16'sd250);
         5'd5:    d = mk_desc(6'd39, 6'd16, F_GYR,   -16'sd250);
         5'd6:    d = mk_desc(6'd7,  6'd16, F_ANG,   -16'sd360);
         5'd7:    d = mk_desc(6'd23, 6'd16, F_ANG,   -16'sd360);
         5'd8:    d = mk_desc(6'd39, 6'd16, F_ANG,   -16'sd360);
         5'd9:    d = mk_desc(6'd7,  6'd32, F_MILLI, -16'sd10000);
         5'd10:   d = mk_desc(6'd39, 6'd32, F_ONE,   16'sd0);
         5'd11:   d = mk_desc(6'd7,  6'd32, F_DEG7,  -16'sd180);
         5'd12:   d = mk_desc(6'd39, 6'd32, F_DEG7,  -16'sd180);
         5'd13:   d = mk_desc(6'd7,  6'd16, F_SPD,   -16'sd100);
         5'd14:   d = mk_desc(6'd23, 6'd16, F_SPD,   -16'sd100);
         5'd15:   d = mk_desc(6'd39, 6'd16, F_SPD,   -16'sd100);
         5'd16:   d = mk_desc(6'd7,  6'd8,  F_ONE,   16'sd0);
         5'd17:   d = mk_desc(6'd15, 6'd8,  F_ONE,   16'sd0);
         5'd18:   d = mk_desc(6'd23, 6'd8,  F_ONE,   16'sd0);
         5'd19:   d = mk_desc(6'd31, 6'd8,  F_ONE,   16'sd0);
         5'd20:   d = mk_desc(6'd39, 6'd8,  F_ONE,   16'sd0);
         5'd21:   d = mk_desc(6'd47, 6'd8,  F_ONE,   16'sd0);
         5'd22:   d = mk_desc(6'd7,  6'd16, F_MILLI, 16'sd0);
         5'd23:   d = mk_desc(6'd23, 6'd16, F_MILLI, 16'sd0);
         5'd24:   d = mk_desc(6'd39, 6'd16, F_MILLI, 16'sd0);
         5'd25:   d = mk_desc(6'd55, 6'd16, F_CENTI, 16'sd0);
         default: d = mk_desc(6'd0,  6'd0,  '0,      16'sd0);
      endcase
      return d;
   endfunction

   // signal list of each identifier 0x500..0x507, by the low three bits
   function automatic group_type cfd_group(input logic [2:0] sel);
      group_type g;
      case (sel)
         3'd0:    g = '{first: 5'd0,  count: 3'd3};
         3'd1:    g = '{first: 5'd3,  count: 3'd3};
         3'd2:    g = '{first: 5'd6,  count: 3'd3};
         3'd3:    g = '{first: 5'd9,  count: 3'd2};
         3'd4:    g = '{first: 5'd11, count: 3'd2};
         3'd5:    g = '{first: 5'd13, count: 3'd3};
         3'd6:    g = '{first: 5'd16, count: 3'd6};
         3'd7:    g = '{first: 5'd22, count: 3'd4};
         default: g = '{first: 5'd0,  count: 3'd1};
      endcase
      return g;
   endfunction

endpackage

// ===== sv/cfd_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_seq
// Frame sequencer: holds one frame and issues one signal job per cycle while
// task_ready is high, taking the next frame in the cycle its last job leaves.
// ----------------------------------------------------------------------------
module cfd_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [cfd_pkg::ID_W-1:0]     in_frame_id,
   input  logic [cfd_pkg::DATA_W-1:0]   in_frame_data,
   output logic                         task_valid,
   input  logic                         task_ready,
   output cfd_pkg::task_type            task_info,
   output logic [cfd_pkg::DATA_W-1:0]   task_data
);

   logic                          busy_ff, busy_in;
   logic                          unknown_ff, unknown_in;
   logic [cfd_pkg::IDX_W-1:0]     first_ff, first_in;
   logic [cfd_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [cfd_pkg::CNT_W-1:0]     step_ff, step_in;
   logic [cfd_pkg::DATA_W-1:0]    data_ff, data_in;
   cfd_pkg::group_type            grp;
   logic                          is_last;
   logic                          load;
   logic                          issue;

   // describe the job at the current step
   always_comb begin
      is_last           = ((step_ff + 3'd1) == count_ff);
      task_valid        = busy_ff;
      task_info.index   = unknown_ff ? '0 : (first_ff + 5'(step_ff));
      task_info.unknown = unknown_ff;
      task_info.last    = is_last;
      task_data         = data_ff;
   end

   assign issue    = busy_ff && task_ready;
   assign in_ready = !busy_ff || (task_ready && is_last);
   assign load     = in_valid && in_ready;
   assign grp      = cfd_pkg::cfd_group(in_frame_id[2:0]);

   // load a new frame, or advance through the held one
   always_comb begin
      busy_in    = busy_ff;
      unknown_in = unknown_ff;
      first_in   = first_ff;
      count_in   = count_ff;
      step_in    = step_ff;
      data_in    = data_ff;
      if (load) begin
         busy_in    = 1'b1;
         unknown_in = (in_frame_id[10:3] != cfd_pkg::ID_GROUP_BASE);
         first_in   = grp.first;
         count_in   = unknown_in ? 3'd1 : grp.count;
         step_in    = '0;
         data_in    = in_frame_data;
      end else if (issue) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      unknown_ff <= unknown_in;
      first_ff   <= first_in;
      count_ff   <= count_in;
      step_ff    <= step_in;
      data_ff    <= data_in;
   end

endmodule

// ===== sv/can_signal_frame_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_signal_frame_decoder
// Decodes Motorola-order signals of CAN frames 0x500..0x507 into raw and
// scaled (signed Q32.32) values, one result per signal.
// ----------------------------------------------------------------------------
// A frame produces one result per signal of its identifier (2 to 6, one per
// cycle unless stalled), or a single unknown_id result for any other
// identifier; the next frame is taken in the cycle its last result enters
// the pipeline. The pipeline stages are the job register, field extraction,
// 32x24 multiplies, rounding, and offset add with saturation. Backpressure on
// rsp_ready holds every full stage that cannot advance, without loss.
module can_signal_frame_decoder #(
   parameter int NUM_SIGNALS    = cfd_pkg::NUM_SIGNALS,
   parameter int MAX_FIELD_BITS = cfd_pkg::MAX_FIELD_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [cfd_pkg::ID_W-1:0]            req_frame_id,
   input  logic [cfd_pkg::DATA_W-1:0]          req_frame_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [cfd_pkg::IDX_W-1:0]           rsp_signal_index,
   output logic [cfd_pkg::RAW_W-1:0]           rsp_raw_value,
   output logic signed [cfd_pkg::SCALED_W-1:0] rsp_scaled_value,
   output logic                                rsp_unknown_id,
   output logic                                rsp_last
);

   // longest field that is extracted
   localparam int FIELD_LIMIT = (MAX_FIELD_BITS < 32) ? MAX_FIELD_BITS : 32;

   logic                          task_valid;
   cfd_pkg::task_type             task_info;
   logic [cfd_pkg::DATA_W-1:0]    task_data;

   // stage valid bits and ready chain
   logic s1_valid_ff, s1_valid_in, s1_rdy;
   logic s2_valid_ff, s2_valid_in, s2_rdy;
   logic s3_valid_ff, s3_valid_in, s3_rdy;
   logic s4_valid_ff, s4_valid_in, s4_rdy;
   logic rsp_valid_ff, rsp_valid_in, rsp_rdy;

   // stage payloads
   cfd_pkg::task_type             s1_task_ff, s1_task_in;
   logic [cfd_pkg::DATA_W-1:0]    s1_data_ff, s1_data_in;
   cfd_pkg::meta_type             s2_meta_ff, s2_meta_in;
   logic [cfd_pkg::FACTOR_W-1:0]  s2_factor_ff, s2_factor_in;
   cfd_pkg::meta_type             s3_meta_ff, s3_meta_in;
   logic [cfd_pkg::PROD_W-1:0]    s3_hi_ff, s3_hi_in;
   logic [cfd_pkg::PROD_W-1:0]    s3_lo_ff, s3_lo_in;
   cfd_pkg::meta_type             s4_meta_ff, s4_meta_in;
   logic [cfd_pkg::SCALED_W-1:0]  s4_mag_ff, s4_mag_in;
   logic                          s4_ovf_ff, s4_ovf_in;
   cfd_pkg::meta_type             rsp_meta_ff, rsp_meta_in;
   logic [cfd_pkg::SCALED_W-1:0]  rsp_scaled_ff, rsp_scaled_in;

   // extraction helpers
   cfd_pkg::desc_type             desc;
   logic [5:0]                    len_eff;
   logic [5:0]                    msb_pos;
   logic [6:0]                    shift;
   logic [cfd_pkg::DATA_W-1:0]    be_data;
   logic [95:0]                   wide;
   logic [cfd_pkg::RAW_W-1:0]     mask;
   logic                          in_range;

   // rounding and offset helpers
   logic [cfd_pkg::PROD_W:0]      lo_rounded;
   logic [65:0]                   off_ext;
   logic [65:0]                   sum;

   cfd_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .in_frame_id   (req_frame_id),
      .in_frame_data (req_frame_data),
      .task_valid    (task_valid),
      .task_ready    (s1_rdy),
      .task_info     (task_info),
      .task_data     (task_data)
   );

   // each stage takes new data when it is empty or its successor moves
   assign rsp_rdy = !rsp_valid_ff || rsp_ready;
   assign s4_rdy  = !s4_valid_ff || rsp_rdy;
   assign s3_rdy  = !s3_valid_ff || s4_rdy;
   assign s2_rdy  = !s2_valid_ff || s3_rdy;
   assign s1_rdy  = !s1_valid_ff || s2_rdy;

   assign s1_valid_in  = s1_rdy  ? task_valid  : s1_valid_ff;
   assign s2_valid_in  = s2_rdy  ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in  = s3_rdy  ? s2_valid_ff : s3_valid_ff;
   assign s4_valid_in  = s4_rdy  ? s3_valid_ff : s4_valid_ff;
   assign rsp_valid_in = rsp_rdy ? s4_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // stage 1: register the job
   assign s1_task_in = task_info;
   assign s1_data_in = task_data;

   // stage 2: look up the descriptor and pull the field out in Motorola order
   always_comb begin
      desc = cfd_pkg::cfd_rom(s1_task_ff.index);
      len_eff = (desc.len > 6'(FIELD_LIMIT)) ? 6'(FIELD_LIMIT) : desc.len;
      // reverse byte order so the field is one contiguous run below its MSB
      for (int k = 0; k < 8; k++) begin
         be_data[(7-k)*8 +: 8] = s1_data_ff[k*8 +: 8];
      end
      msb_pos  = {~desc.start[5:3], desc.start[2:0]};
      shift    = 7'(msb_pos) + 7'd33 - 7'(len_eff);
      wide     = {be_data, 32'b0} >> shift;
      mask     = 32'((33'd1 << len_eff) - 33'd1);
      in_range = ({2'b00, s1_task_ff.index} < 7'(NUM_SIGNALS)) && !s1_task_ff.unknown;
      s2_meta_in.index   = s1_task_ff.index;
      s2_meta_in.unknown = s1_task_ff.unknown;
      s2_meta_in.last    = s1_task_ff.last;
      s2_meta_in.raw     = in_range ? (wide[31:0] & mask) : '0;
      s2_meta_in.offset  = in_range ? desc.offset : '0;
      s2_factor_in       = in_range ? desc.factor : '0;
   end

   // stage 3: split product against the two factor halves
   always_comb begin
      s3_meta_in = s2_meta_ff;
      s3_hi_in   = s2_meta_ff.raw * s2_factor_ff[cfd_pkg::FACTOR_W-1:cfd_pkg::HALF_W];
      s3_lo_in   = s2_meta_ff.raw * s2_factor_ff[cfd_pkg::HALF_W-1:0];
   end

   // stage 4: round to Q32.32 and join the halves, flag overflow
   always_comb begin
      s4_meta_in = s3_meta_ff;
      lo_rounded = {1'b0, s3_lo_ff} + {1'b0, cfd_pkg::ROUND_HALF};
      s4_ovf_in  = (s3_hi_ff >= cfd_pkg::OVF_LIMIT);
      s4_mag_in  = {s3_hi_ff[54:0], 9'b0} + 64'(lo_rounded[cfd_pkg::PROD_W:15]);
   end

   // stage 5: add the offset and saturate to the signed range
   always_comb begin
      rsp_meta_in = s4_meta_ff;
      off_ext     = {{18{s4_meta_ff.offset[cfd_pkg::OFF_W-1]}}, s4_meta_ff.offset, 32'b0};
      sum         = {2'b00, s4_mag_ff} + off_ext;
      if (s4_ovf_ff || (!sum[65] && (sum[64] || sum[63]))) begin
         rsp_scaled_in = cfd_pkg::SCALED_MAX;
      end else begin
         rsp_scaled_in = sum[63:0];
      end
   end

   // hold payloads while stalled, load on advance
   always_ff @(posedge clock) begin
      if (s1_rdy && task_valid) begin
         s1_task_ff <= s1_task_in;
         s1_data_ff <= s1_data_in;
      end
      if (s2_rdy && s1_valid_ff) begin
         s2_meta_ff   <= s2_meta_in;
         s2_factor_ff <= s2_factor_in;
      end
      if (s3_rdy && s2_valid_ff) begin
         s3_meta_ff <= s3_meta_in;
         s3_hi_ff   <= s3_hi_in;
         s3_lo_ff   <= s3_lo_in;
      end
      if (s4_rdy && s3_valid_ff) begin
         s4_meta_ff <= s4_meta_in;
         s4_mag_ff  <= s4_mag_in;
         s4_ovf_ff  <= s4_ovf_in;
      end
      if (rsp_rdy && s4_valid_ff) begin
         rsp_meta_ff   <= rsp_meta_in;
         rsp_scaled_ff <= rsp_scaled_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_signal_index = rsp_meta_ff.index;
   assign rsp_raw_value    = rsp_meta_ff.raw;
   assign rsp_scaled_value = rsp_scaled_ff;
   assign rsp_unknown_id   = rsp_meta_ff.unknown;
   assign rsp_last         = rsp_meta_ff.last;

endmodule

// ===== sv/cfd_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_check
// Port-level checks for the CAN signal frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module cfd_check (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [cfd_pkg::IDX_W-1:0]           rsp_signal_index,
   input logic [cfd_pkg::RAW_W-1:0]           rsp_raw_value,
   input logic signed [cfd_pkg::SCALED_W-1:0] rsp_scaled_value,
   input logic                                rsp_unknown_id,
   input logic                                rsp_last
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // the error result is a single, all-zero transfer
   a_unknown_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_unknown_id) |->
         (rsp_last && rsp_signal_index == '0 && rsp_raw_value == '0
          && rsp_scaled_value == '0))
      else $error("malformed unknown identifier result");

   // a frame's final result is always the end of its signal list
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last && !rsp_unknown_id) |->
         (rsp_signal_index == 5'd2  || rsp_signal_index == 5'd5  ||
          rsp_signal_index == 5'd8  || rsp_signal_index == 5'd10 ||
          rsp_signal_index == 5'd12 || rsp_signal_index == 5'd15 ||
          rsp_signal_index == 5'd21 || rsp_signal_index == 5'd25))
      else $error("last flag on a signal that does not end a list");

   // within a frame, signals follow in ROM order
   a_index_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=>
         (!rsp_valid || rsp_signal_index == $past(rsp_signal_index) + 5'd1))
      else $error("signal index out of order within a frame");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_signal_index) && $stable(rsp_raw_value)
          && $stable(rsp_scaled_value) && $stable(rsp_last)))
      else $error("result changed while stalled");

endmodule

bind can_signal_frame_decoder cfd_check u_cfd_check (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_signal_index (rsp_signal_index),
   .rsp_raw_value    (rsp_raw_value),
   .rsp_scaled_value (rsp_scaled_value),
   .rsp_unknown_id   (rsp_unknown_id),
   .rsp_last         (rsp_last)
);
